[sv/sirt_pkg.sv]
// sirt_pkg: shared types, constants and the digit-to-character map for the
// signed integer to radix text unit. No dependencies.
package sirt_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [DIGIT_W-1:0] BASE_MIN      = 6'd2;
    localparam logic [DIGIT_W-1:0] BASE_MAX      = 6'd36;
    localparam logic [DIGIT_W-1:0] HIGHEST_DIGIT = 6'd35;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch a new value and base, clear the counters
        logic div_step;   // one restoring-division bit
        logic store;      // write the remainder digit, start the next division
        logic rd_en;      // read the digit store at the current top digit
        logic out_sign;   // load '-' into the output register
        logic out_digit;  // load the digit just read, drop the digit count
        logic out_empty;  // load the empty-result beat
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic base_ok;
        logic bit_done;
        logic quot_zero;
        logic digits_full;
        logic last_digit;
        logic negative;
        logic out_free;
    } sts_t;

    // Digit table, folded: digits above the highest map to 'z'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dd;
        dd = (d > HIGHEST_DIGIT) ? HIGHEST_DIGIT : d;
        if (dd < 6'd10)
            return CHAR_ZERO + {1'b0, dd};
        else
            return CHAR_A + {1'b0, dd - 6'd10};
    endfunction

endpackage

[sv/sirt_ram.sv]
// sirt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sirt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/sirt_ctrl.sv]
// sirt_ctrl: sequencing state machine for the radix text unit.
// Depends on sirt_pkg (cmd_t, sts_t).
module sirt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sirt_pkg::sts_t sts,
    output sirt_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BAD   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.base_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_BAD;
                    end
                end
            end
            ST_BAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.bit_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.quot_zero || sts.digits_full)
                begin
                    state_next = sts.negative ? ST_SIGN : ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_sign = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_digit = 1'b1;
                    state_next    = sts.last_digit ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Output loads only happen while the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_sign || cmd.out_digit || cmd.out_empty) |-> sts.out_free)
        else $error("output register loaded while occupied");

    // A division always ends in a digit store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.bit_done) |=> (state_reg == ST_STORE))
        else $error("division finished without storing a digit");

    // Every digit read is followed by its emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (state_reg == ST_EMIT))
        else $error("digit read not followed by emit");

endmodule

[sv/sirt_dpath.sv]
// sirt_dpath: bit-serial divider, digit counters, digit store and output register.
// Depends on sirt_pkg and sirt_ram.
module sirt_dpath #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    input  logic [sirt_pkg::DIGIT_W-1:0]      base,
    input  sirt_pkg::cmd_t                    cmd,
    output sirt_pkg::sts_t                    sts,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [sirt_pkg::CHAR_W-1:0]       character,
    output logic                              is_last,
    output logic                              empty_res
);

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int DW = sirt_pkg::DIGIT_W;

    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          base_reg;
    logic                   neg_reg;
    logic [BW-1:0]          bit_cnt_reg;
    logic [CW-1:0]          digit_cnt_reg;
    logic                   out_valid_reg;
    logic [sirt_pkg::CHAR_W-1:0] char_reg;
    logic                   last_reg;
    logic                   empty_reg;

    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   ge;
    logic [DW-1:0]          rem_next;
    logic [CW-1:0]          rd_ptr;
    logic [DW-1:0]          rd_digit;
    logic                   out_free;

    // Restoring division step: shift in the next quotient bit.
    assign trial    = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign ge       = (trial >= {1'b0, base_reg});
    assign diff     = trial - {1'b0, base_reg};
    assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign rd_ptr   = digit_cnt_reg - CW'(1);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
            rem_reg  <= '0;
            base_reg <= base;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[VALUE_WIDTH-2:0], ge};
            rem_reg  <= rem_next;
        end
        else if (cmd.store)
        begin
            rem_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                neg_reg       <= value[VALUE_WIDTH-1];
                bit_cnt_reg   <= '0;
                digit_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + BW'(1);
            end
            else if (cmd.store)
            begin
                bit_cnt_reg   <= '0;
                digit_cnt_reg <= digit_cnt_reg + CW'(1);
            end
            else if (cmd.out_digit)
            begin
                digit_cnt_reg <= rd_ptr;
            end
        end
    end

    sirt_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_DIGITS)
    ) u_digits (
        .clk    (clk),
        .wr_en  (cmd.store),
        .wr_addr(digit_cnt_reg[AW-1:0]),
        .wr_data(rem_reg),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_ptr[AW-1:0]),
        .rd_data(rd_digit)
    );

    // Output register: hold until taken, reload only when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_sign || cmd.out_digit || cmd.out_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_sign)
        begin
            char_reg  <= sirt_pkg::CHAR_MINUS;
            last_reg  <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (cmd.out_digit)
        begin
            char_reg  <= sirt_pkg::digit_char(rd_digit);
            last_reg  <= (digit_cnt_reg == CW'(1));
            empty_reg <= 1'b0;
        end
        else if (cmd.out_empty)
        begin
            char_reg  <= sirt_pkg::CHAR_NONE;
            last_reg  <= 1'b1;
            empty_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign is_last   = last_reg;
    assign empty_res = empty_reg;

    assign sts.base_ok     = (base >= sirt_pkg::BASE_MIN) && (base <= sirt_pkg::BASE_MAX);
    assign sts.bit_done    = (bit_cnt_reg == BW'(VALUE_WIDTH - 1));
    assign sts.quot_zero   = (quot_reg == '0);
    assign sts.digits_full = (digit_cnt_reg == CW'(MAX_DIGITS - 1));
    assign sts.last_digit  = (digit_cnt_reg == CW'(1));
    assign sts.negative    = neg_reg;
    assign sts.out_free    = out_free;

    // The partial remainder stays below the base through every division.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (rem_reg < base_reg))
        else $error("remainder not below base at digit store");

    // Digit writes stay inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (digit_cnt_reg < CW'(MAX_DIGITS)))
        else $error("digit store overflow");

    // A digit is only emitted while digits remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.out_digit) |-> (digit_cnt_reg != '0))
        else $error("digit emitted with empty digit count");

endmodule

[sv/signed_integer_to_radix_text_unit.sv]
// signed_integer_to_radix_text_unit: top level of the signed integer to radix
// text converter. Depends on sirt_pkg, sirt_ctrl, sirt_dpath (and sirt_ram).
//
//   channel | direction | handshake                 | beat payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | sink      | in_valid / in_stall       | value, base
//   out     | source    | out_valid / out_stall     | character, is_last, empty_res
//
// Sequence: a valid base is loaded, then each digit comes from the shared
// bit-serial divider (one quotient bit a cycle) and goes into the digit
// store; then '-' goes out on a negative value, and each digit is read back
// from the digit store and loaded into the output register, top digit first;
// an invalid base gives only its single empty beat.
// Reset clears the controller and counters; the digit store is not cleared.
// Output stalls hold the output register and pause the emit sequence; the next
// beat is accepted as soon as the last result sits in the output register.
module signed_integer_to_radix_text_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic [sirt_pkg::DIGIT_W-1:0]  base,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sirt_pkg::CHAR_W-1:0]   character,
    output logic                          is_last,
    output logic                          empty_res
);

    sirt_pkg::cmd_t cmd;
    sirt_pkg::sts_t sts;

    // Controller: accepts a beat only in idle, then sequences divide and emit.
    sirt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: divider, digit store and the output register.
    sirt_dpath #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .base     (base),
        .cmd      (cmd),
        .sts      (sts),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .character(character),
        .is_last  (is_last),
        .empty_res(empty_res)
    );

endmodule

[tb/sv/radix_text_checker.sv]
// radix_text_checker: watches both channels of the radix text unit, predicts
// the character beats of every accepted value and compares them in order.
// Depends on sirt_pkg for the character and digit constants.
module radix_text_checker #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic [sirt_pkg::DIGIT_W-1:0]  base,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [sirt_pkg::CHAR_W-1:0]   character,
    input  logic                          is_last,
    input  logic                          empty_res,
    output int                            fail_count,
    output int                            chars_due
);

    localparam int REPORT_LIMIT = 10;

    // Digit glyphs, digit 0 in the top byte and digit 35 in the bottom byte.
    localparam logic [8*36-1:0] GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

    typedef struct packed {
        logic [sirt_pkg::CHAR_W-1:0] character;
        logic                        is_last;
        logic                        empty_res;
    } text_beat_t;

    text_beat_t                    text_due[$];
    logic [sirt_pkg::DIGIT_W-1:0]  digit_buf[MAX_DIGITS];
    int                            digit_total;
    logic                          sign_latched;
    logic [VALUE_WIDTH-1:0]        quot;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Push the beats that one accepted value and base produce.
    function automatic void queue_text(input logic [VALUE_WIDTH-1:0] raw,
                                       input logic [sirt_pkg::DIGIT_W-1:0] radix);
        logic [VALUE_WIDTH-1:0]       rdx;
        logic [VALUE_WIDTH-1:0]       rem;
        logic [sirt_pkg::DIGIT_W-1:0] dig;
        text_beat_t                   beat;
        int                           k;
        if (radix < sirt_pkg::BASE_MIN || radix > sirt_pkg::BASE_MAX) begin
            beat.character = sirt_pkg::CHAR_NONE;
            beat.is_last   = 1'b1;
            beat.empty_res = 1'b1;
            text_due.push_back(beat);
            return;
        end
        rdx          = VALUE_WIDTH'(radix);
        sign_latched = raw[VALUE_WIDTH-1];
        quot         = sign_latched ? (~raw + 1'b1) : raw;
        digit_total  = 0;
        do begin
            rem                    = quot % rdx;
            digit_buf[digit_total] = rem[sirt_pkg::DIGIT_W-1:0];
            quot                   = quot / rdx;
            digit_total++;
        end while (quot != 0 && digit_total < MAX_DIGITS);
        beat.empty_res = 1'b0;
        if (sign_latched) begin
            beat.character = sirt_pkg::CHAR_MINUS;
            beat.is_last   = 1'b0;
            text_due.push_back(beat);
        end
        for (k = digit_total - 1; k >= 0; k--) begin
            dig = digit_buf[k];
            if (dig > sirt_pkg::HIGHEST_DIGIT)
                dig = sirt_pkg::HIGHEST_DIGIT;
            beat.character = GLYPHS[8*(int'(sirt_pkg::HIGHEST_DIGIT) - int'(dig))
                                    +: sirt_pkg::CHAR_W];
            beat.is_last   = (k == 0);
            text_due.push_back(beat);
        end
    endfunction

    // Outputs first: a beat leaving at this edge belongs to an earlier value.
    always @(posedge clk) begin : watch
        text_beat_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (text_due.size() == 0) begin
                    note_failure($sformatf("unexpected beat: char %h last %b empty %b",
                                           character, is_last, empty_res));
                end else begin
                    want = text_due.pop_front();
                    if (character !== want.character || is_last !== want.is_last ||
                        empty_res !== want.empty_res)
                        note_failure($sformatf(
                            "beat mismatch: char %h/%h last %b/%b empty %b/%b (exp/got)",
                            want.character, character, want.is_last, is_last,
                            want.empty_res, empty_res));
                end
            end
            if (in_valid && !in_stall)
                queue_text(value, base);
        end
        chars_due <= text_due.size();
    end

endmodule

[tb/sv/tb_signed_integer_to_radix_text_unit.sv]
// tb_signed_integer_to_radix_text_unit: stimulus and verdict for the signed
// integer to radix text unit. Depends on sirt_pkg, the unit and radix_text_checker.
module tb_signed_integer_to_radix_text_unit;

    localparam int VALUE_WIDTH      = 32;
    localparam int MAX_DIGITS       = 32;
    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 6;
    // A 32-digit conversion runs long with no handshake at all, and the long
    // receiver hold adds LONG_HOLD; allow many times that.
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int LONG_HOLD        = 1500;
    localparam int TAIL_CYCLES      = 200;
    localparam int RANDOM_PER_PHASE = 31;
    localparam int PRESSURE_ITEMS   = 12;

    logic                                clk;
    logic                                rst_n      = 1'b0;
    logic                                in_valid   = 1'b0;
    logic                                in_stall;
    logic signed [VALUE_WIDTH-1:0]       value      = '0;
    logic [sirt_pkg::DIGIT_W-1:0]        base       = '0;
    logic                                out_valid;
    logic                                out_stall  = 1'b0;
    logic [sirt_pkg::CHAR_W-1:0]         character;
    logic                                is_last;
    logic                                empty_res;

    int   fail_count;
    int   chars_due;
    int   idle_cycles    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    // Toggle to ask the receiver process for one long hold.
    logic hold_token     = 1'b0;
    logic hold_seen      = 1'b0;

    signed_integer_to_radix_text_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .base      (base),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .is_last   (is_last),
        .empty_res (empty_res)
    );

    radix_text_checker #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .base       (base),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .character  (character),
        .is_last    (is_last),
        .empty_res  (empty_res),
        .fail_count (fail_count),
        .chars_due  (chars_due)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Abort when neither channel moves a beat for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall at random each cycle, or hold off for the whole LONG_HOLD
    // stretch when the stimulus flips hold_token.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Offer one beat from a falling edge; return at the falling edge after
    // it was taken. Idle cycles come before valid rises, never while it is up,
    // so valid stays high from one beat to the next when no gap is drawn.
    task automatic send_beat(input logic [VALUE_WIDTH-1:0] v,
                             input logic [sirt_pkg::DIGIT_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        base     <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted character has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (chars_due != 0) @(negedge clk);
    endtask

    // Mix full-range values, short magnitudes of random length, tiny values
    // and values next to both extremes; negate some of them.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        int                     kind;
        kind = $urandom_range(0, 99);
        if (kind < 35)
            v = $urandom;
        else if (kind < 60)
            v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
        else if (kind < 75)
            v = $urandom_range(0, 40);
        else if (kind < 85)
            v = 32'h8000_0000 + $urandom_range(0, 3);
        else
            v = 32'h7fff_ffff - $urandom_range(0, 3);
        if (kind >= 35 && kind < 75 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // Mostly legal radixes; about one in eight is out of range on either side.
    function automatic logic [sirt_pkg::DIGIT_W-1:0] pick_base();
        logic [sirt_pkg::DIGIT_W-1:0] b;
        if ($urandom_range(0, 99) < 12)
            b = sirt_pkg::DIGIT_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                        : $urandom_range(37, 63));
        else
            b = sirt_pkg::DIGIT_W'($urandom_range(int'(sirt_pkg::BASE_MIN),
                                                  int'(sirt_pkg::BASE_MAX)));
        return b;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct   = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (count) send_beat(pick_value(), pick_base());
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero, one, extremes in the narrowest and widest radix,
        // the top digit 'z', digit rollover, and out-of-range radixes.
        send_beat(0, 10);
        send_beat(1, 2);
        send_beat(-1, 10);
        send_beat(32'h7fff_ffff, 10);
        send_beat(32'h8000_0000, 10);
        send_beat(32'h8000_0000, 2);
        send_beat(32'h7fff_ffff, 2);
        send_beat(32'h8000_0000, 16);
        send_beat(32'h7fff_ffff, 36);
        send_beat(32'h8000_0000, 36);
        send_beat(35, 36);
        send_beat(-35, 36);
        send_beat(10, 11);
        send_beat(255, 16);
        send_beat(-255, 16);
        send_beat(1295, 36);
        send_beat(36, 36);
        send_beat(0, 0);
        send_beat(5, 1);
        send_beat(5, 37);
        send_beat(-7, 63);
        send_beat(123456789, 3);
        send_beat(-987654321, 7);
        send_beat(0, 2);
        wait_drained();

        // Random: no idling, sender gaps, receiver stalls, then both.
        run_phase(0, 0, RANDOM_PER_PHASE);
        run_phase(84, 0, RANDOM_PER_PHASE);
        run_phase(0, 84, RANDOM_PER_PHASE);
        run_phase(20, 20, RANDOM_PER_PHASE);

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the unit fills and stalls its input; then the sender pauses
        // until every character is out.
        hold_token <= ~hold_token;
        run_phase(0, 0, PRESSURE_ITEMS);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && chars_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[signed_integer_to_radix_text_unit.f]
sv/sirt_pkg.sv
sv/sirt_ram.sv
sv/sirt_ctrl.sv
sv/sirt_dpath.sv
sv/signed_integer_to_radix_text_unit.sv
tb/sv/radix_text_checker.sv
tb/sv/tb_signed_integer_to_radix_text_unit.sv
